// ----- hw/rtl/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and face codes for the cube face selection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

	localparam int unsigned OUT_BITS  = 16;
	localparam int unsigned FACE_BITS = 3;

	localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
	localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
	localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
	localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
	localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
	localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

	typedef struct packed {
		logic                 valid;
		logic [FACE_BITS-1:0] face;
		logic                 neg_u;
		logic                 neg_v;
		logic                 zero;
	} cfs_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cfs_face_sel.sv -----
// ----------------------------------------------------------------------------
// cfs_face_sel
// Major axis pick, face code, minor numerators and signs; one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_face_sel #(
	parameter int unsigned COMPONENT_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic [COMPONENT_BITS-1:0] dir_x,
	input  wire logic [COMPONENT_BITS-1:0] dir_y,
	input  wire logic [COMPONENT_BITS-1:0] dir_z,
	output cfs_pkg::cfs_ctrl_t             ctrl_s1,
	output logic [COMPONENT_BITS-1:0]      den_s1,
	output logic [COMPONENT_BITS-1:0]      num_u_s1,
	output logic [COMPONENT_BITS-1:0]      num_v_s1
);
	import cfs_pkg::*;

	logic                      nx, ny, nz;
	logic [COMPONENT_BITS-1:0] mx, my, mz;
	logic                      is_zero;
	cfs_ctrl_t                 ctrl_d;
	logic [COMPONENT_BITS-1:0] den_d, num_u_d, num_v_d;

	assign nx = dir_x[COMPONENT_BITS-1];
	assign ny = dir_y[COMPONENT_BITS-1];
	assign nz = dir_z[COMPONENT_BITS-1];
	assign mx = nx ? (~dir_x + 1'b1) : dir_x;
	assign my = ny ? (~dir_y + 1'b1) : dir_y;
	assign mz = nz ? (~dir_z + 1'b1) : dir_z;
	assign is_zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

	always_comb begin
		ctrl_d       = '0;
		ctrl_d.valid = accept;
		ctrl_d.zero  = is_zero;
		den_d        = '0;
		num_u_d      = '0;
		num_v_d      = '0;
		if (is_zero) begin
			// den of one, zero numerators: quotients come out zero
			ctrl_d.face = FACE_POS_X;
			den_d       = COMPONENT_BITS'(1);
		end else if (mx >= my && mx >= mz) begin
			den_d        = mx;
			num_u_d      = my;
			num_v_d      = mz;
			ctrl_d.face  = nx ? FACE_NEG_X : FACE_POS_X;
			ctrl_d.neg_u = nx ? !ny : ny;
			ctrl_d.neg_v = nz;
		end else if (my >= mz) begin
			den_d        = my;
			num_u_d      = mx;
			num_v_d      = mz;
			ctrl_d.face  = ny ? FACE_NEG_Y : FACE_POS_Y;
			ctrl_d.neg_u = ny ? nx : !nx;
			ctrl_d.neg_v = nz;
		end else begin
			den_d        = mz;
			num_u_d      = my;
			num_v_d      = mx;
			ctrl_d.face  = nz ? FACE_NEG_Z : FACE_POS_Z;
			ctrl_d.neg_u = ny;
			ctrl_d.neg_v = nz ? !nx : nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		den_s1   <= den_d;
		num_u_s1 <= num_u_d;
		num_v_s1 <= num_v_d;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cfs_div_cell.sv -----
// ----------------------------------------------------------------------------
// cfs_div_cell
// One restoring division step for the u and v lanes; registered hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_div_cell #(
	parameter int unsigned COMPONENT_BITS = 16,
	parameter int unsigned QUOT_BITS      = 15
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cfs_pkg::cfs_ctrl_t        ctrl_in,
	input  wire logic [COMPONENT_BITS-1:0] den_in,
	input  wire logic [COMPONENT_BITS-1:0] rem_u_in,
	input  wire logic [COMPONENT_BITS-1:0] rem_v_in,
	input  wire logic [QUOT_BITS-1:0]      q_u_in,
	input  wire logic [QUOT_BITS-1:0]      q_v_in,
	output cfs_pkg::cfs_ctrl_t             ctrl_q,
	output logic [COMPONENT_BITS-1:0]      den_q,
	output logic [COMPONENT_BITS-1:0]      rem_u_q,
	output logic [COMPONENT_BITS-1:0]      rem_v_q,
	output logic [QUOT_BITS-1:0]           q_u_q,
	output logic [QUOT_BITS-1:0]           q_v_q
);
	import cfs_pkg::*;

	logic                      ge_u, ge_v;
	logic [COMPONENT_BITS-1:0] ru, rv;

	assign ge_u = rem_u_in >= den_in;
	assign ge_v = rem_v_in >= den_in;
	assign ru   = ge_u ? (rem_u_in - den_in) : rem_u_in;
	assign rv   = ge_v ? (rem_v_in - den_in) : rem_v_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	// remainder stays below den, so the shift never drops a set bit
	always_ff @(posedge clk) begin
		den_q   <= den_in;
		rem_u_q <= {ru[COMPONENT_BITS-2:0], 1'b0};
		rem_v_q <= {rv[COMPONENT_BITS-2:0], 1'b0};
		q_u_q   <= {q_u_in[QUOT_BITS-2:0], ge_u};
		q_v_q   <= {q_v_in[QUOT_BITS-2:0], ge_v};
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cube_face_select_project.sv -----
// ----------------------------------------------------------------------------
// cube_face_select_project
// Cube map face selection and face coordinate projection.
// ----------------------------------------------------------------------------
// Usage:
//   Drive dir_x/dir_y/dir_z and raise start; a transfer happens at each edge
//   with start high and busy low. busy is always low, so a new direction may
//   be given every cycle.
//   Each direction yields one result: face_index, coord_u, coord_v and
//   zero_vector, shown for one cycle with done high.
//   The pipeline has one stage for the face pick, one divider cell per
//   quotient bit (FRACTION_BITS + 1 cells) and one output stage.
//   Throughput is one direction per cycle; the cell row works on
//   FRACTION_BITS + 1 directions at once.
//   u and v are minor/major in Q1.FRACTION_BITS, truncated toward zero,
//   reduced to 16 bits. An all-zero direction gives face 0, zero u and v and
//   zero_vector high.
//   Reset clears every valid flag, so no done appears until new transfers
//   arrive. The receiver cannot stall: done is not held off.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_face_select_project #(
	parameter int unsigned COMPONENT_BITS = 16,
	parameter int unsigned FRACTION_BITS  = 14
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [COMPONENT_BITS-1:0] dir_x,
	input  wire logic [COMPONENT_BITS-1:0] dir_y,
	input  wire logic [COMPONENT_BITS-1:0] dir_z,
	output logic                           done,
	output logic [cfs_pkg::FACE_BITS-1:0]  face_index,
	output logic [cfs_pkg::OUT_BITS-1:0]   coord_u,
	output logic [cfs_pkg::OUT_BITS-1:0]   coord_v,
	output logic                           zero_vector
);
	import cfs_pkg::*;

	localparam int unsigned QW    = FRACTION_BITS + 1;
	localparam int unsigned CELLS = QW;
	localparam int unsigned EW    = (QW > OUT_BITS) ? QW : OUT_BITS;

	cfs_ctrl_t                 ctrl_c  [0:CELLS];
	logic [COMPONENT_BITS-1:0] den_c   [0:CELLS];
	logic [COMPONENT_BITS-1:0] rem_u_c [0:CELLS];
	logic [COMPONENT_BITS-1:0] rem_v_c [0:CELLS];
	logic [QW-1:0]             q_u_c   [0:CELLS];
	logic [QW-1:0]             q_v_c   [0:CELLS];

	logic [EW-1:0]             qe_u, qe_v, se_u, se_v;
	logic                      done_q;
	logic [FACE_BITS-1:0]      face_q;
	logic [OUT_BITS-1:0]       u_q, v_q;
	logic                      zero_q;

	assign busy = 1'b0;

	cfs_face_sel #(
		.COMPONENT_BITS(COMPONENT_BITS)
	) u_face_sel (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (start && !busy),
		.dir_x   (dir_x),
		.dir_y   (dir_y),
		.dir_z   (dir_z),
		.ctrl_s1 (ctrl_c[0]),
		.den_s1  (den_c[0]),
		.num_u_s1(rem_u_c[0]),
		.num_v_s1(rem_v_c[0])
	);

	assign q_u_c[0] = '0;
	assign q_v_c[0] = '0;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		cfs_div_cell #(
			.COMPONENT_BITS(COMPONENT_BITS),
			.QUOT_BITS     (QW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl_in (ctrl_c[i]),
			.den_in  (den_c[i]),
			.rem_u_in(rem_u_c[i]),
			.rem_v_in(rem_v_c[i]),
			.q_u_in  (q_u_c[i]),
			.q_v_in  (q_v_c[i]),
			.ctrl_q  (ctrl_c[i+1]),
			.den_q   (den_c[i+1]),
			.rem_u_q (rem_u_c[i+1]),
			.rem_v_q (rem_v_c[i+1]),
			.q_u_q   (q_u_c[i+1]),
			.q_v_q   (q_v_c[i+1])
		);
	end

	assign qe_u = EW'(q_u_c[CELLS]);
	assign qe_v = EW'(q_v_c[CELLS]);
	assign se_u = ctrl_c[CELLS].neg_u ? EW'(~qe_u + 1'b1) : qe_u;
	assign se_v = ctrl_c[CELLS].neg_v ? EW'(~qe_v + 1'b1) : qe_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_c[CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		face_q <= ctrl_c[CELLS].face;
		zero_q <= ctrl_c[CELLS].zero;
		u_q    <= se_u[OUT_BITS-1:0];
		v_q    <= se_v[OUT_BITS-1:0];
	end

	assign done        = done_q;
	assign face_index  = face_q;
	assign coord_u     = u_q;
	assign coord_v     = v_q;
	assign zero_vector = zero_q;

endmodule

`default_nettype wire

// ----- tb/sv/cube_face_select_project_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_face_select_project_tb
// Drives directions into the cube face pipeline and checks the face index,
// u, v and zero flag of every result against an in-bench projection of the
// same direction. A directed set covers the axis extremes, ties, each face
// and the zero vector. Random directions follow, in three rounds of input
// pacing: light gaps, heavy gaps, then back to back.
// ----------------------------------------------------------------------------

module cube_face_select_project_tb;

	import cfs_pkg::*;

	localparam int PIPE_DEPTH   = 17;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int ROUND_ITEMS  = 210;

	typedef struct {
		logic [FACE_BITS-1:0] face;
		logic [OUT_BITS-1:0]  u;
		logic [OUT_BITS-1:0]  v;
		logic                 zero;
	} face_t;

	class face_checker;
		face_t pending_faces[$];
		int    checked;
		int    errors;
		int    zeros;
		int    face_hits[6];

		function logic [OUT_BITS-1:0] scale_minor(logic neg, logic [16:0] num,
			logic [16:0] den);
			logic [31:0] q;
			q = ({15'd0, num} << 14) / {15'd0, den};
			if (neg)
				q = 32'd0 - q;
			return q[OUT_BITS-1:0];
		endfunction

		function face_t project_direction(logic [15:0] x, logic [15:0] y,
			logic [15:0] z);
			logic [16:0] mx, my, mz;
			face_t r;
			mx = x[15] ? 17'h10000 - {1'b0, x} : {1'b0, x};
			my = y[15] ? 17'h10000 - {1'b0, y} : {1'b0, y};
			mz = z[15] ? 17'h10000 - {1'b0, z} : {1'b0, z};
			r.zero = 1'b0;
			if (mx == 0 && my == 0 && mz == 0) begin
				r.face = FACE_POS_X;
				r.u    = '0;
				r.v    = '0;
				r.zero = 1'b1;
			end else if (mx >= my && mx >= mz) begin
				r.face = x[15] ? FACE_NEG_X : FACE_POS_X;
				r.u    = scale_minor(y[15] ^ x[15], my, mx);
				r.v    = scale_minor(z[15], mz, mx);
			end else if (my >= mz) begin
				r.face = y[15] ? FACE_NEG_Y : FACE_POS_Y;
				r.u    = scale_minor(~(x[15] ^ y[15]), mx, my);
				r.v    = scale_minor(z[15], mz, my);
			end else begin
				r.face = z[15] ? FACE_NEG_Z : FACE_POS_Z;
				r.u    = scale_minor(y[15], my, mz);
				r.v    = scale_minor(x[15] ^ z[15], mx, mz);
			end
			return r;
		endfunction

		function void note_direction(logic [15:0] x, logic [15:0] y, logic [15:0] z);
			pending_faces.push_back(project_direction(x, y, z));
		endfunction

		function void check_face(face_t got);
			face_t want;
			if (pending_faces.size() == 0) begin
				$error("result with no transfer pending: face_index %0d", got.face);
				errors++;
				return;
			end
			want = pending_faces.pop_front();
			checked++;
			if (want.zero)
				zeros++;
			else if (want.face < 6)
				face_hits[want.face]++;
			if (got.face !== want.face) begin
				$error("face_index: expected %0d, got %0d", want.face, got.face);
				errors++;
			end
			if (got.u !== want.u) begin
				$error("coord_u: expected %0d, got %0d", $signed(want.u), $signed(got.u));
				errors++;
			end
			if (got.v !== want.v) begin
				$error("coord_v: expected %0d, got %0d", $signed(want.v), $signed(got.v));
				errors++;
			end
			if (got.zero !== want.zero) begin
				$error("zero_vector: expected %0d, got %0d", want.zero, got.zero);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [15:0]          dir_x;
	logic [15:0]          dir_y;
	logic [15:0]          dir_z;
	logic                 done;
	logic [FACE_BITS-1:0] face_index;
	logic [OUT_BITS-1:0]  coord_u;
	logic [OUT_BITS-1:0]  coord_v;
	logic                 zero_vector;

	face_checker board;
	int          cycles;
	int          sent;

	cube_face_select_project u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.dir_z      (dir_z),
		.done       (done),
		.face_index (face_index),
		.coord_u    (coord_u),
		.coord_v    (coord_v),
		.zero_vector(zero_vector)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// results first, then the transfer seen at the same edge
	always @(posedge clk) begin
		face_t got;
		if (arst_n && board != null) begin
			if (done) begin
				got.face = face_index;
				got.u    = coord_u;
				got.v    = coord_v;
				got.zero = zero_vector;
				board.check_face(got);
			end
			if (start && !busy) begin
				board.note_direction(dir_x, dir_y, dir_z);
				sent++;
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_direction(int x, int y, int z, int idle_pct);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		dir_x <= x[15:0];
		dir_y <= y[15:0];
		dir_z <= z[15:0];
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	function automatic logic [15:0] random_component(int mode);
		logic [15:0] c;
		case (mode)
			0: c = 16'($urandom);
			1: c = 16'($urandom_range(15)) ^ ($urandom_range(1) ? 16'hFFFF : 16'h0000);
			2: begin
				case ($urandom_range(5))
					0: c = 16'h8000;
					1: c = 16'h7FFF;
					2: c = 16'h8001;
					3: c = 16'h0001;
					4: c = 16'hFFFF;
					default: c = 16'h0000;
				endcase
			end
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

	task automatic send_random_round(int count, int idle_pct);
		logic [15:0] c[3];
		int a, b;
		repeat (count) begin
			for (int i = 0; i < 3; i++)
				c[i] = random_component(0);
			case ($urandom_range(9))
				5, 6: begin
					// tie between two axes, random signs
					a = $urandom_range(2);
					b = (a + 1 + $urandom_range(1)) % 3;
					c[b] = $urandom_range(1) ? 16'd0 - c[a] : c[a];
				end
				7: for (int i = 0; i < 3; i++)
					c[i] = random_component(1);
				8: begin
					c[$urandom_range(2)] = 16'h0000;
					if ($urandom_range(1))
						c[$urandom_range(2)] = 16'h0000;
				end
				9: for (int i = 0; i < 3; i++)
					c[i] = random_component($urandom_range(2));
				default: ;
			endcase
			send_direction(c[0], c[1], c[2], idle_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		dir_x  = '0;
		dir_y  = '0;
		dir_z  = '0;
		cycles = 0;
		sent   = 0;
		board  = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_direction(0, 0, 0, 0);
		send_direction(32767, 0, 0, 0);
		send_direction(-32768, 0, 0, 0);
		send_direction(0, 32767, 0, 0);
		send_direction(0, -32768, 0, 0);
		send_direction(0, 0, 32767, 0);
		send_direction(0, 0, -32768, 0);
		send_direction(5, 5, 5, 0);
		send_direction(-5, 5, -5, 0);
		send_direction(0, 7, -7, 0);
		send_direction(3, -7, 7, 0);
		send_direction(-32768, -32768, -32768, 0);
		send_direction(-32768, 32767, -32767, 0);
		send_direction(32767, -32768, 32767, 0);
		send_direction(1, -1, 1, 28);
		send_direction(-1, 2, -3, 28);
		send_direction(100, -99, 1, 28);
		send_direction(-100, 99, -1, 28);
		send_direction(3, 1000, -2, 28);
		send_direction(-3, -1000, 2, 28);
		send_direction(7, -1, 1000, 28);
		send_direction(-7, 1, -1000, 28);
		send_direction(32767, 32767, 0, 28);

		send_random_round(ROUND_ITEMS, 28);
		send_random_round(ROUND_ITEMS, 66);
		send_random_round(ROUND_ITEMS, 0);
		start <= 1'b0;

		while (board.pending_faces.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);

		if (board.pending_faces.size() != 0) begin
			$error("%0d results never arrived", board.pending_faces.size());
			board.errors++;
		end
		$display("%0d directions transferred, %0d results checked, %0d zero vectors",
			sent, board.checked, board.zeros);
		$display("faces +x %0d -x %0d +y %0d -y %0d +z %0d -z %0d",
			board.face_hits[0], board.face_hits[1], board.face_hits[2],
			board.face_hits[3], board.face_hits[4], board.face_hits[5]);
		if (board.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
